// ===== rtl/rvex_pkg.sv =====
// Shared types, codes and constants of the RV32I execute unit.
`default_nettype none
package rvex_pkg;

    localparam int REG_COUNT = 32;
    localparam int RF_AW = $clog2(REG_COUNT);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [3:0] CMD_ALU_REG = 4'd0;
    localparam logic [3:0] CMD_ALU_IMM = 4'd1;
    localparam logic [3:0] CMD_LOAD = 4'd2;
    localparam logic [3:0] CMD_STORE = 4'd3;
    localparam logic [3:0] CMD_BRANCH = 4'd4;
    localparam logic [3:0] CMD_JAL = 4'd5;
    localparam logic [3:0] CMD_JALR = 4'd6;
    localparam logic [3:0] CMD_LUI = 4'd7;
    localparam logic [3:0] CMD_AUIPC = 4'd8;
    localparam logic [3:0] CMD_SYSTEM = 4'd9;
    localparam logic [3:0] CMD_LOAD_RETURN = 4'd10;

    localparam logic [3:0] K_ALU = 4'd0;
    localparam logic [3:0] K_LOAD = 4'd1;
    localparam logic [3:0] K_STORE = 4'd2;
    localparam logic [3:0] K_BRANCH = 4'd3;
    localparam logic [3:0] K_JAL = 4'd4;
    localparam logic [3:0] K_JALR = 4'd5;
    localparam logic [3:0] K_LUI = 4'd6;
    localparam logic [3:0] K_AUIPC = 4'd7;
    localparam logic [3:0] K_SYSTEM = 4'd8;
    localparam logic [3:0] K_LOAD_RETURN = 4'd9;
    localparam logic [3:0] K_INVALID = 4'd10;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_HALT = 3'd2;
    localparam logic [2:0] ST_BREAK = 3'd3;
    localparam logic [2:0] ST_MEMERR = 3'd4;

    localparam logic [1:0] MREQ_NONE = 2'd0;
    localparam logic [1:0] MREQ_READ = 2'd1;
    localparam logic [1:0] MREQ_WRITE = 2'd2;

    localparam logic [6:0] F7_ALT = 7'h20;
    localparam logic [4:0] ECALL_REG = 5'd17;
    localparam logic [31:0] ECALL_EXIT = 32'd93;

    typedef struct packed {
        logic [3:0] cmd;
        logic [2:0] funct3;
        logic [6:0] funct7;
        logic [4:0] dest_index;
        logic [4:0] src1_index;
        logic [4:0] src2_index;
        logic signed [31:0] immediate;
        logic [31:0] insn_address;
        logic [31:0] mem_data;
        logic mem_fault;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [31:0] next_pc;
        logic [1:0] mem_request;
        logic [31:0] mem_address;
        logic [1:0] mem_size;
        logic [31:0] mem_write_data;
        logic reg_written;
        logic [4:0] reg_index;
        logic [31:0] reg_value;
    } res_item_t;

    typedef struct packed {
        logic [3:0] kind;
        logic alt;
        logic use_imm;
        logic [2:0] funct3;
        logic [4:0] rd;
        logic [4:0] rs1;
        logic [4:0] rs2;
        logic [31:0] imm;
        logic [31:0] pc;
        logic [31:0] mem_data;
        logic mem_fault;
    } op_item_t;

endpackage
`default_nettype wire

// ===== rtl/rvex_ram.sv =====
// Generic single-write, single-read RAM with registered read.
`default_nettype none
module rvex_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rvex_front.sv =====
// Front end: classify each incoming item and check its encoding.
`default_nettype none
module rvex_front (
    input  wire rvex_pkg::cmd_item_t item,
    output rvex_pkg::op_item_t       op
);

    logic valid_r;

    always_comb
    begin
        valid_r = (item.funct7 == 7'd0) ||
                  (item.funct7 == rvex_pkg::F7_ALT &&
                   (item.funct3 == 3'd0 || item.funct3 == 3'd5));
        op.alt = 1'b0;
        op.use_imm = 1'b0;
        op.funct3 = item.funct3;
        op.rd = item.dest_index;
        op.rs1 = item.src1_index;
        op.rs2 = item.src2_index;
        op.imm = item.immediate;
        op.pc = item.insn_address;
        op.mem_data = item.mem_data;
        op.mem_fault = item.mem_fault;
        op.kind = rvex_pkg::K_INVALID;
        unique case (item.cmd)
            rvex_pkg::CMD_ALU_REG:
            begin
                op.kind = valid_r ? rvex_pkg::K_ALU : rvex_pkg::K_INVALID;
                op.alt = item.funct7 == rvex_pkg::F7_ALT;
            end
            rvex_pkg::CMD_ALU_IMM:
            begin
                op.kind = rvex_pkg::K_ALU;
                op.use_imm = 1'b1;
                op.alt = item.funct3 == 3'd5 && item.funct7[5];
            end
            rvex_pkg::CMD_LOAD:
                op.kind = (item.funct3 == 3'd3 || item.funct3 > 3'd5) ?
                          rvex_pkg::K_INVALID : rvex_pkg::K_LOAD;
            rvex_pkg::CMD_STORE:
                op.kind = (item.funct3 > 3'd2) ? rvex_pkg::K_INVALID : rvex_pkg::K_STORE;
            rvex_pkg::CMD_BRANCH:
                op.kind = (item.funct3 == 3'd2 || item.funct3 == 3'd3) ?
                          rvex_pkg::K_INVALID : rvex_pkg::K_BRANCH;
            rvex_pkg::CMD_JAL:         op.kind = rvex_pkg::K_JAL;
            rvex_pkg::CMD_JALR:        op.kind = rvex_pkg::K_JALR;
            rvex_pkg::CMD_LUI:         op.kind = rvex_pkg::K_LUI;
            rvex_pkg::CMD_AUIPC:       op.kind = rvex_pkg::K_AUIPC;
            rvex_pkg::CMD_SYSTEM:
                op.kind = (item.funct3 != 3'd0) ? rvex_pkg::K_INVALID : rvex_pkg::K_SYSTEM;
            rvex_pkg::CMD_LOAD_RETURN: op.kind = rvex_pkg::K_LOAD_RETURN;
            default:                   op.kind = rvex_pkg::K_INVALID;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/rvex_queue.sv =====
// Two-entry queue between front end and back end.
`default_nettype none
module rvex_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire rvex_pkg::op_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output logic                    nonempty,
    output rvex_pkg::op_item_t      head
);

    rvex_pkg::op_item_t slot_reg [rvex_pkg::QUEUE_DEPTH];
    logic wptr_reg, wptr_next;
    logic rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;

    assign full = count_reg == 2'(rvex_pkg::QUEUE_DEPTH);
    assign nonempty = count_reg != 2'd0;
    assign head = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nonempty)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(rvex_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== rtl/rvex_back.sv =====
// Back end: register file read, execute, write back and result register.
`default_nettype none
module rvex_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_nonempty,
    input  wire rvex_pkg::op_item_t q_head,
    output logic                    q_pop,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output rvex_pkg::res_item_t     res_item
);

    localparam int AW = rvex_pkg::RF_AW;

    logic adv;
    logic s2_valid_reg;
    rvex_pkg::op_item_t s2_reg;
    logic fwd1_reg, fwd2_reg;
    logic vld1_reg, vld2_reg;
    logic [31:0] fwd_val_reg;
    logic [31:0] q1, q2;
    logic [rvex_pkg::REG_COUNT-1:0] valid_reg;
    logic [31:0] x17_reg;
    logic lp_reg, lp_next;
    logic [4:0] pdest_reg, pdest_next;
    logic [2:0] pwk_reg, pwk_next;
    logic out_valid_reg;
    rvex_pkg::res_item_t out_reg, res;

    logic wr_en;
    logic [4:0] wr_idx;
    logic [31:0] v1, v2, b, alu_r, seq, ldv, x17v;
    logic [4:0] sh;
    logic taken, ok1, ok2;
    logic [4:0] widx;
    logic [31:0] wval;
    logic wreq;

    assign adv = !out_valid_reg || !res_stall;
    assign q_pop = adv && q_nonempty;
    assign res_valid = out_valid_reg;
    assign res_item = out_reg;
    assign wr_en = adv && s2_valid_reg && res.reg_written;
    assign wr_idx = res.reg_index;

    rvex_ram #(.WIDTH(32), .DEPTH(rvex_pkg::REG_COUNT)) u_rf1 (
        .clk(clk), .we(wr_en), .waddr(wr_idx[AW-1:0]), .wdata(res.reg_value),
        .re(adv), .raddr(q_head.rs1[AW-1:0]), .rdata(q1)
    );
    rvex_ram #(.WIDTH(32), .DEPTH(rvex_pkg::REG_COUNT)) u_rf2 (
        .clk(clk), .we(wr_en), .waddr(wr_idx[AW-1:0]), .wdata(res.reg_value),
        .re(adv), .raddr(q_head.rs2[AW-1:0]), .rdata(q2)
    );

    always_comb
    begin
        ok1 = s2_reg.rs1 != 5'd0 && 32'(s2_reg.rs1) < rvex_pkg::REG_COUNT;
        ok2 = s2_reg.rs2 != 5'd0 && 32'(s2_reg.rs2) < rvex_pkg::REG_COUNT;
        v1 = !ok1 ? 32'd0 : fwd1_reg ? fwd_val_reg : vld1_reg ? q1 : 32'd0;
        v2 = !ok2 ? 32'd0 : fwd2_reg ? fwd_val_reg : vld2_reg ? q2 : 32'd0;
        x17v = (32'(rvex_pkg::ECALL_REG) < rvex_pkg::REG_COUNT) ? x17_reg : 32'd0;
        b = s2_reg.use_imm ? s2_reg.imm : v2;
        sh = b[4:0];
        seq = s2_reg.pc + 32'd4;
        unique case (s2_reg.funct3)
            3'd0: alu_r = s2_reg.alt ? v1 - b : v1 + b;
            3'd1: alu_r = v1 << sh;
            3'd2: alu_r = 32'($signed(v1) < $signed(b));
            3'd3: alu_r = 32'(v1 < b);
            3'd4: alu_r = v1 ^ b;
            3'd5: alu_r = s2_reg.alt ? 32'($signed(v1) >>> sh) : v1 >> sh;
            3'd6: alu_r = v1 | b;
            default: alu_r = v1 & b;
        endcase
        unique case (s2_reg.funct3)
            3'd0: taken = v1 == v2;
            3'd1: taken = v1 != v2;
            3'd4: taken = $signed(v1) < $signed(v2);
            3'd5: taken = !($signed(v1) < $signed(v2));
            3'd6: taken = v1 < v2;
            3'd7: taken = v1 >= v2;
            default: taken = 1'b0;
        endcase
        unique case (pwk_reg)
            3'd0: ldv = {{24{s2_reg.mem_data[7]}}, s2_reg.mem_data[7:0]};
            3'd1: ldv = {{16{s2_reg.mem_data[15]}}, s2_reg.mem_data[15:0]};
            3'd4: ldv = {24'd0, s2_reg.mem_data[7:0]};
            3'd5: ldv = {16'd0, s2_reg.mem_data[15:0]};
            default: ldv = s2_reg.mem_data;
        endcase

        res = '0;
        res.status = rvex_pkg::ST_OK;
        res.next_pc = seq;
        lp_next = lp_reg;
        pdest_next = pdest_reg;
        pwk_next = pwk_reg;
        wreq = 1'b0;
        widx = s2_reg.rd;
        wval = 32'd0;
        unique case (s2_reg.kind)
            rvex_pkg::K_ALU:
            begin
                wreq = 1'b1;
                wval = alu_r;
            end
            rvex_pkg::K_LOAD:
            begin
                res.mem_request = rvex_pkg::MREQ_READ;
                res.mem_address = v1 + s2_reg.imm;
                res.mem_size = s2_reg.funct3[1:0];
                lp_next = 1'b1;
                pdest_next = s2_reg.rd;
                pwk_next = s2_reg.funct3;
            end
            rvex_pkg::K_STORE:
            begin
                res.mem_request = rvex_pkg::MREQ_WRITE;
                res.mem_address = v1 + s2_reg.imm;
                res.mem_size = s2_reg.funct3[1:0];
                res.mem_write_data = (s2_reg.funct3 == 3'd0) ? {24'd0, v2[7:0]} :
                                     (s2_reg.funct3 == 3'd1) ? {16'd0, v2[15:0]} : v2;
            end
            rvex_pkg::K_BRANCH:
                res.next_pc = taken ? s2_reg.pc + s2_reg.imm : seq;
            rvex_pkg::K_JAL:
            begin
                wreq = 1'b1;
                wval = seq;
                res.next_pc = s2_reg.pc + s2_reg.imm;
            end
            rvex_pkg::K_JALR:
            begin
                wreq = 1'b1;
                wval = seq;
                res.next_pc = (v1 + s2_reg.imm) & ~32'd1;
            end
            rvex_pkg::K_LUI:
            begin
                wreq = 1'b1;
                wval = s2_reg.imm;
            end
            rvex_pkg::K_AUIPC:
            begin
                wreq = 1'b1;
                wval = s2_reg.pc + s2_reg.imm;
            end
            rvex_pkg::K_SYSTEM:
            begin
                if (s2_reg.imm == 32'd0 && x17v == rvex_pkg::ECALL_EXIT)
                begin
                    res.status = rvex_pkg::ST_HALT;
                end
                else if (s2_reg.imm == 32'd1)
                begin
                    res.status = rvex_pkg::ST_BREAK;
                end
            end
            rvex_pkg::K_LOAD_RETURN:
            begin
                res.next_pc = 32'd0;
                if (!lp_reg)
                begin
                    res.status = rvex_pkg::ST_INVALID;
                end
                else
                begin
                    lp_next = 1'b0;
                    if (s2_reg.mem_fault)
                    begin
                        res.status = rvex_pkg::ST_MEMERR;
                    end
                    else
                    begin
                        wreq = 1'b1;
                        widx = pdest_reg;
                        wval = ldv;
                    end
                end
            end
            default:
            begin
                res.status = rvex_pkg::ST_INVALID;
                res.next_pc = s2_reg.pc;
            end
        endcase
        if (wreq && widx != 5'd0 && 32'(widx) < rvex_pkg::REG_COUNT)
        begin
            res.reg_written = 1'b1;
            res.reg_index = widx;
            res.reg_value = wval;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg <= '0;
            x17_reg <= 32'd0;
            lp_reg <= 1'b0;
            pdest_reg <= 5'd0;
            pwk_reg <= 3'd0;
        end
        else if (adv)
        begin
            s2_valid_reg <= q_nonempty;
            out_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
            begin
                lp_reg <= lp_next;
                pdest_reg <= pdest_next;
                pwk_reg <= pwk_next;
            end
            if (wr_en)
            begin
                valid_reg[wr_idx[AW-1:0]] <= 1'b1;
                if (wr_idx == rvex_pkg::ECALL_REG)
                begin
                    x17_reg <= res.reg_value;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg <= q_head;
            fwd1_reg <= wr_en && wr_idx == q_head.rs1;
            fwd2_reg <= wr_en && wr_idx == q_head.rs2;
            fwd_val_reg <= res.reg_value;
            vld1_reg <= valid_reg[q_head.rs1[AW-1:0]];
            vld2_reg <= valid_reg[q_head.rs2[AW-1:0]];
            if (s2_valid_reg)
            begin
                out_reg <= res;
            end
        end
    end

    a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_idx != 5'd0 && 32'(wr_idx) < rvex_pkg::REG_COUNT))
        else $error("write to x0 or beyond register count");
    a_lret_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s2_valid_reg && s2_reg.kind == rvex_pkg::K_LOAD_RETURN) |=> !lp_reg)
        else $error("load return left a load pending");
    a_invalid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == rvex_pkg::ST_INVALID) |->
        (!out_reg.reg_written && out_reg.mem_request == rvex_pkg::MREQ_NONE))
        else $error("invalid item changed state");

endmodule
`default_nettype wire

// ===== rtl/rv32i_execute_unit_top.sv =====
// Top level of the RV32I execute unit.
//   channel | direction | handshake            | payload
//   cmd     | in        | cmd_valid, cmd_stall | cmd_item (cmd_item_t)
//   res     | out       | res_valid, res_stall | res_item (res_item_t)
// One item per cycle sustained while res_stall is low; an accepted item goes from
// the queue to register file read, then executes into the result register.
// The register file is two RAM copies with registered read and write bypass.
// Reset clears the queue, the pipeline valids, the register valid bits and load state.
// A stalled result holds the back end; the two-entry queue then fills and
// raises cmd_stall.
`default_nettype none
module rv32i_execute_unit_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_stall,
    input  wire rvex_pkg::cmd_item_t  cmd_item,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output rvex_pkg::res_item_t       res_item
);

    rvex_pkg::op_item_t op, head;
    logic full, nonempty, pop;

    assign cmd_stall = full;

    rvex_front u_front (
        .item(cmd_item),
        .op(op)
    );

    rvex_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(cmd_valid && !full), .push_item(op), .full(full),
        .pop(pop), .nonempty(nonempty), .head(head)
    );

    rvex_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_nonempty(nonempty), .q_head(head), .q_pop(pop),
        .res_valid(res_valid), .res_stall(res_stall), .res_item(res_item)
    );

endmodule
`default_nettype wire
